@@ rtl/core/class_baseline_zscore_qc_top_assert.svh @@
// ----------------------------------------------------------------------------
// class baseline z-score check: assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CLASS_BASELINE_ZSCORE_QC_TOP_ASSERT_SVH
`define CLASS_BASELINE_ZSCORE_QC_TOP_ASSERT_SVH

// same-cycle implication
`define CBZQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cbzq assertion failed");

// next-cycle implication
`define CBZQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbzq assertion failed");

`endif

@@ rtl/core/cbzq_pkg.sv @@
// ----------------------------------------------------------------------------
// cbzq_pkg
// shared types, codes and widths of the class baseline z-score check
// ----------------------------------------------------------------------------
package cbzq_pkg;

  localparam int MAX_CLASSES_DEF = 256;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int SUM_W  = 32;
  localparam int SQ_W   = 48;
  localparam int OUT_W  = 24;
  localparam int DVD_W  = 88;
  localparam int DVS_W  = 48;
  localparam int STEP_W = 7;
  localparam int ROW_W  = SUM_W + SQ_W;

  localparam logic [1:0] OP_ACC = 2'd0;
  localparam logic [1:0] OP_QRY = 2'd1;
  localparam logic [1:0] OP_CLR = 2'd2;

  localparam logic [1:0] V_PASS = 2'd0;
  localparam logic [1:0] V_WARN = 2'd1;
  localparam logic [1:0] V_FLAG = 2'd2;

  localparam logic REG_WARN = 1'b0;
  localparam logic REG_FLAG = 1'b1;

  typedef enum logic [1:0] {K_ACC, K_QRY, K_CLR, K_NOP} kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  cls;
    logic        in_range;
    logic [15:0] value;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [15:0] warn;
    logic [15:0] flag;
  } cfg_t;

endpackage

@@ rtl/core/class_baseline_zscore_qc_top.sv @@
// ----------------------------------------------------------------------------
// class_baseline_zscore_qc_top
// per-class baseline statistics with a z-score pass/warn/flag check
// ----------------------------------------------------------------------------
//  channel  | handshake               | carries
//  ---------+-------------------------+--------------------------------------
//  in       | in_valid_i / in_stall_o | op, class_index, value, last_of_sample
//  out      | out_valid_o/out_stall_i | answered, mean, spread, zscore, verdict
//  cfg      | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
//  accumulate reads and writes its class row and op 3 goes straight to the result;
//  clear also sweeps all MAX_CLASSES table rows; a query's length is set by the shared
//  one-bit-per-cycle divider (41 + 88 + 35 steps) and the 24-step square root
//  reset starts a clearing sweep of all MAX_CLASSES table rows before any beat is
//  executed; input beats are still queued during it
//  a two-beat queue parts input from execution; a waiting result is held in
//  the output register while the queue keeps filling
module class_baseline_zscore_qc_top #(
  parameter int MAX_CLASSES = cbzq_pkg::MAX_CLASSES_DEF,
  parameter int VALUE_BITS  = cbzq_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS  = cbzq_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         class_index_i,
  input  logic [15:0]        value_i,
  input  logic               last_of_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               answered_o,
  output logic [23:0]        expected_mean_o,
  output logic [23:0]        spread_o,
  output logic signed [15:0] zscore_o,
  output logic               z_infinite_o,
  output logic [1:0]         verdict_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_wdata_i
);
  import cbzq_pkg::*;

  // threshold registers; the user must write them only while idle, the block does not enforce it
  cfg_t  cfg_q;
  logic  q_valid, q_pop;
  item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn <= 16'd512;
      cfg_q.flag <= 16'd768;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WARN: cfg_q.warn <= cfg_wdata_i;
        REG_FLAG: cfg_q.flag <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // front: decode and queue input beats
  cbzq_front #(.MAX_CLASSES(MAX_CLASSES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .class_index_i    (class_index_i),
    .value_i          (value_i),
    .last_of_sample_i (last_of_sample_i),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  // back: table, sequencer and result register
  cbzq_back #(.MAX_CLASSES(MAX_CLASSES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .answered_o      (answered_o),
    .expected_mean_o (expected_mean_o),
    .spread_o        (spread_o),
    .zscore_o        (zscore_o),
    .z_infinite_o    (z_infinite_o),
    .verdict_o       (verdict_o)
  );
endmodule

@@ rtl/core/cbzq_ram.sv @@
// ----------------------------------------------------------------------------
// cbzq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cbzq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/core/cbzq_div.sv @@
// ----------------------------------------------------------------------------
// cbzq_div
// restoring divider, one quotient bit per cycle, dividend top-aligned
// ----------------------------------------------------------------------------
module cbzq_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cbzq_pkg::DVD_W-1:0] dividend_i,
  input  logic [cbzq_pkg::DVS_W-1:0] divisor_i,
  input  logic [cbzq_pkg::STEP_W-1:0] steps_i,
  output logic                       done_o,
  output logic [cbzq_pkg::DVD_W-1:0] quot_o
);
  import cbzq_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVD_W-1:0]  dvd_q, quo_q;
  logic [DVS_W:0]    rem2;
  logic              ge;

  assign rem2 = {rem_q, dvd_q[DVD_W-1]};
  assign ge   = rem2 >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      dvd_q <= dividend_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DVS_W'(rem2 - {1'b0, dvs_q}) : DVS_W'(rem2);
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

@@ rtl/core/cbzq_front.sv @@
// ----------------------------------------------------------------------------
// cbzq_front
// input beat acceptance, op decode and a two-entry queue to the back end
// ----------------------------------------------------------------------------
module cbzq_front #(
  parameter int MAX_CLASSES = cbzq_pkg::MAX_CLASSES_DEF,
  parameter int VALUE_BITS  = cbzq_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          class_index_i,
  input  logic [15:0]         value_i,
  input  logic                last_of_sample_i,
  output logic                q_valid_o,
  output cbzq_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);
  import cbzq_pkg::*;

  localparam int VB = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam logic [15:0] VMASK = 16'((32'd1 << VB) - 1);

  item_t       slot_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  item_t       it;
  logic        push;

  always_comb begin
    unique case (op_i)
      OP_ACC:  it.kind = K_ACC;
      OP_QRY:  it.kind = K_QRY;
      OP_CLR:  it.kind = K_CLR;
      default: it.kind = K_NOP;
    endcase
    it.cls      = class_index_i;
    it.in_range = 32'(class_index_i) < MAX_CLASSES;
    it.value    = value_i & VMASK;
    it.last     = last_of_sample_i;
  end

  assign in_stall_o = cnt_q == 2'd2;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= it;
  end
endmodule

@@ rtl/core/cbzq_back.sv @@
// ----------------------------------------------------------------------------
// cbzq_back
// table update, statistics sequencer and result register
// ----------------------------------------------------------------------------
module cbzq_back #(
  parameter int MAX_CLASSES = cbzq_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = cbzq_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbzq_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  cbzq_pkg::item_t      q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 answered_o,
  output logic [23:0]          expected_mean_o,
  output logic [23:0]          spread_o,
  output logic signed [15:0]   zscore_o,
  output logic                 z_infinite_o,
  output logic [1:0]           verdict_o
);
  import cbzq_pkg::*;

  localparam int AW = $clog2(MAX_CLASSES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MEAN = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_MUL4 = 4'd7;
  localparam logic [3:0] S_SUB  = 4'd8;
  localparam logic [3:0] S_VDIV = 4'd9;
  localparam logic [3:0] S_SQRT = 4'd10;
  localparam logic [3:0] S_Z    = 4'd11;
  localparam logic [3:0] S_ZDIV = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0]            state_q;
  logic [AW-1:0]         clr_q;
  item_t                 it_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SQ_W-1:0]       sq_q;
  logic [OUT_W-1:0]      mean_q, sd_q;
  logic [47:0]           plo_q, phi_q, dd_q;
  logic [63:0]           bb_q;
  logic [71:0]           a_q;
  logic [47:0]           sx_q, sr_q, one_q;
  logic signed [15:0]    z_q;
  logic                  inf_q, neg_q;

  logic                  ov_q, ans_q, inf_o_q;
  logic [OUT_W-1:0]      mean_o_q, sd_o_q;
  logic signed [15:0]    z_o_q;
  logic [1:0]            vd_q;

  logic [ROW_W-1:0]      rdata, wdata;
  logic [AW-1:0]         raddr, waddr, it_addr;
  logic                  we;
  logic                  div_start, div_done;
  logic [DVD_W-1:0]      div_dvd, quot;
  logic [DVS_W-1:0]      div_dvs;
  logic [STEP_W-1:0]     div_steps;

  logic [23:0]           n24;
  logic [SUM_W:0]        s_new;
  logic [SQ_W:0]         q_new;
  logic [SUM_W-1:0]      rd_sum;
  logic [SQ_W-1:0]       rd_sq;
  logic [40:0]           md;
  logic [71:0]           num;
  logic signed [24:0]    diff;
  logic [24:0]           mag;
  logic [34:0]           zd;
  logic [47:0]           sq_try;
  logic [15:0]           az;
  logic [1:0]            verdict;
  logic                  out_free;

  assign n24     = 24'(cnt_q);
  assign raddr   = AW'({{AW{1'b0}}, q_item_i.cls});
  assign it_addr = AW'({{AW{1'b0}}, it_q.cls});
  assign rd_sum  = it_q.in_range ? rdata[SUM_W-1:0] : '0;
  assign rd_sq   = it_q.in_range ? rdata[ROW_W-1:SUM_W] : '0;
  assign s_new   = {1'b0, rd_sum} + (SUM_W+1)'(it_q.value);
  assign q_new   = {1'b0, rd_sq} + (SQ_W+1)'(32'(it_q.value) * 32'(it_q.value));
  assign md      = {1'b0, rd_sum, 8'b0} + 41'(n24 >> 1);
  assign num     = (a_q < {8'b0, bb_q}) ? 72'd0 : a_q - {8'b0, bb_q};
  assign diff    = $signed({1'b0, it_q.value, 8'b0}) - $signed({1'b0, mean_q});
  assign mag     = diff[24] ? 25'(-diff) : 25'(diff);
  assign zd      = 35'({mag, 9'b0}) + 35'(sd_q);
  assign sq_try  = sr_q + one_q;
  assign out_free = !ov_q || !out_stall_i;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  // shared divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    div_steps = '0;
    unique case (state_q)
      S_RD: begin
        div_start = (it_q.kind == K_QRY) && (cnt_q != '0);
        div_dvd   = {md, 47'b0};
        div_dvs   = DVS_W'(n24);
        div_steps = STEP_W'(41);
      end
      S_SUB: begin
        div_start = 1'b1;
        div_dvd   = {num, 16'b0};
        div_dvs   = dd_q;
        div_steps = STEP_W'(DVD_W);
      end
      S_Z: begin
        div_start = sd_q != '0;
        div_dvd   = {zd, 53'b0};
        div_dvs   = DVS_W'({sd_q, 1'b0});
        div_steps = STEP_W'(35);
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = it_addr;
    wdata = {(s_new[SUM_W] ? {SQ_W{1'b1}} : {SQ_W{1'b0}}), SUM_W'(0)};
    wdata = {q_new[SQ_W] ? {SQ_W{1'b1}} : q_new[SQ_W-1:0],
             s_new[SUM_W] ? {SUM_W{1'b1}} : s_new[SUM_W-1:0]};
    if (state_q == S_CLR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (state_q == S_RD && it_q.kind == K_ACC && it_q.in_range) begin
      we = 1'b1;
    end
  end

  always_comb begin
    az = z_q[15] ? 16'(-z_q) : z_q;
    priority if (inf_q || az >= cfg_i.flag) verdict = V_FLAG;
    else if (az >= cfg_i.warn)               verdict = V_WARN;
    else                                     verdict = V_PASS;
  end

  cbzq_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CLASSES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cbzq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_CLASSES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid_i) begin
            if (q_item_i.kind == K_CLR) cnt_q <= '0;
            clr_q   <= '0;
            state_q <= (q_item_i.kind == K_ACC || q_item_i.kind == K_QRY) ? S_RD : S_FIN;
          end
        end
        S_RD: begin
          if (it_q.kind == K_ACC) begin
            if (it_q.last && cnt_q != '1) cnt_q <= cnt_q + COUNT_BITS'(1);
            state_q <= S_FIN;
          end else if (cnt_q != '0) begin
            state_q <= S_MEAN;
          end else begin
            state_q <= S_Z;
          end
        end
        S_MEAN: if (div_done) state_q <= (n24 > 24'd1) ? S_MUL1 : S_Z;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_MUL3;
        S_MUL3: state_q <= S_MUL4;
        S_MUL4: state_q <= S_SUB;
        S_SUB:  state_q <= S_VDIV;
        S_VDIV: if (div_done) state_q <= (quot[DVD_W-1:SQ_W] != '0) ? S_Z : S_SQRT;
        S_SQRT: if (one_q == '0) state_q <= S_Z;
        S_Z:    state_q <= (sd_q == '0) ? S_FIN : S_ZDIV;
        S_ZDIV: if (div_done) state_q <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            state_q <= (it_q.kind == K_CLR) ? S_CLR : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        it_q   <= q_item_i;
        mean_q <= '0;
        sd_q   <= '0;
        z_q    <= '0;
        inf_q  <= 1'b0;
      end
      S_RD: begin
        sum_q <= rd_sum;
        sq_q  <= rd_sq;
      end
      S_MEAN: if (div_done) mean_q <= (quot[DVD_W-1:OUT_W] != '0) ? '1 : quot[OUT_W-1:0];
      S_MUL1: plo_q <= n24 * sq_q[23:0];
      S_MUL2: phi_q <= n24 * sq_q[47:24];
      S_MUL3: bb_q  <= sum_q * sum_q;
      S_MUL4: begin
        dd_q <= n24 * (n24 - 24'd1);
        a_q  <= {24'b0, plo_q} + {phi_q, 24'b0};
      end
      S_VDIV: begin
        if (div_done) begin
          if (quot[DVD_W-1:SQ_W] != '0) sd_q <= '1;
          sx_q  <= quot[SQ_W-1:0];
          sr_q  <= '0;
          one_q <= 48'd1 << 46;
        end
      end
      S_SQRT: begin
        if (one_q == '0) begin
          sd_q <= sr_q[OUT_W-1:0];
        end else begin
          if (sx_q >= sq_try) begin
            sx_q <= sx_q - sq_try;
            sr_q <= (sr_q >> 1) + one_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          one_q <= one_q >> 2;
        end
      end
      S_Z: begin
        neg_q <= diff[24];
        if (sd_q == '0 && !diff[24] && diff != '0) begin
          inf_q <= 1'b1;
          z_q   <= 16'sd32767;
        end
      end
      S_ZDIV: begin
        if (div_done) begin
          if (neg_q) z_q <= (quot > 88'd32768) ? -16'sd32768 : 16'(-quot[15:0]);
          else       z_q <= (quot > 88'd32767) ? 16'sd32767 : $signed(quot[15:0]);
        end
      end
      S_FIN: begin
        if (out_free) begin
          ans_q    <= it_q.kind == K_QRY;
          mean_o_q <= (it_q.kind == K_QRY) ? mean_q : '0;
          sd_o_q   <= (it_q.kind == K_QRY) ? sd_q : '0;
          z_o_q    <= (it_q.kind == K_QRY) ? z_q : '0;
          inf_o_q  <= (it_q.kind == K_QRY) && inf_q;
          vd_q     <= (it_q.kind == K_QRY) ? verdict : V_PASS;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = ov_q;
  assign answered_o      = ans_q;
  assign expected_mean_o = mean_o_q;
  assign spread_o        = sd_o_q;
  assign zscore_o        = z_o_q;
  assign z_infinite_o    = inf_o_q;
  assign verdict_o       = vd_q;
endmodule

@@ rtl/core/cbzq_checker.sv @@
// ----------------------------------------------------------------------------
// cbzq_checker
// port-level properties of the class baseline z-score check
// ----------------------------------------------------------------------------
`include "class_baseline_zscore_qc_top_assert.svh"

module cbzq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               answered_o,
  input logic [23:0]        expected_mean_o,
  input logic [23:0]        spread_o,
  input logic signed [15:0] zscore_o,
  input logic               z_infinite_o,
  input logic [1:0]         verdict_o
);
  import cbzq_pkg::*;

  // infinite z only with zero spread, and always flags
  `CBZQ_ASSERT_NOW(a_inf_flags, clk_i, rst_ni, out_valid_o && z_infinite_o, spread_o == '0 && verdict_o == V_FLAG)
  // acknowledgement beats carry no statistics
  `CBZQ_ASSERT_NOW(a_ack_zero, clk_i, rst_ni, out_valid_o && !answered_o, expected_mean_o == '0 && spread_o == '0 && zscore_o == '0 && verdict_o == V_PASS)
  // zero spread without infinity gives a zero score
  `CBZQ_ASSERT_NOW(a_flat_zero, clk_i, rst_ni, out_valid_o && answered_o && spread_o == '0 && !z_infinite_o, zscore_o == '0)
  // a stalled result beat holds
  `CBZQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(zscore_o) && $stable(verdict_o))
endmodule

bind class_baseline_zscore_qc_top cbzq_checker u_cbzq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .answered_o      (answered_o),
  .expected_mean_o (expected_mean_o),
  .spread_o        (spread_o),
  .zscore_o        (zscore_o),
  .z_infinite_o    (z_infinite_o),
  .verdict_o       (verdict_o)
);
